@@ sv/assert_macros.svh @@
// Assertion macros shared by the sliding window median RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("sliding window median: invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define SWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sliding window median: sequence violated");

`endif

@@ sv/swm_pkg.sv @@
// Package for the sliding window median core: default sizes, register widths
// and the control struct broadcast to the sorted cell row. No dependencies.
package swm_pkg;

    // Default sizes of the core.
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Width and reset value of the window size register.
    localparam int           CFG_W        = 7;
    localparam logic [6:0]   WINDOW_RESET = 7'd3;

    // Fan-in of each first-level node of the median tap tree.
    localparam int GROUP = 8;

    // Control broadcast to every cell of the sorted row.
    typedef struct packed {
        logic load;   // an item is accepted this cycle
        logic full;   // window is full: the oldest sample leaves
    } swm_ctrl_t;

endpackage

@@ sv/swm_cell.sv @@
// One cell of the sorted row: holds one sample and updates it from its
// neighbors on each accepted item. Depends on swm_pkg.
module swm_cell #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  swm_pkg::swm_ctrl_t     ctrl,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] oldest,
    input  logic [CNT_W-1:0]       kept,
    input  logic [SAMPLE_BITS-1:0] right_val,
    input  logic [SAMPLE_BITS-1:0] left_kept_val,
    input  logic                   left_big,
    output logic [SAMPLE_BITS-1:0] val,
    output logic [SAMPLE_BITS-1:0] kept_val,
    output logic                   big
);

    logic [SAMPLE_BITS-1:0] val_reg;
    logic [SAMPLE_BITS-1:0] val_next;
    logic                   kept_valid;
    logic                   shift;

    // Removal: above the removed entry every cell takes its right neighbor.
    // Insertion: cells above the new sample take their left neighbor's value.
    always_comb
    begin
        kept_valid = (CNT_W'(INDEX) < kept);
        shift      = ctrl.full && kept_valid && (right_val > oldest);
        kept_val   = shift ? right_val : val_reg;
        big        = !kept_valid || (kept_val > sample);
        if (big)
        begin
            val_next = left_big ? left_kept_val : sample;
        end
        else
        begin
            val_next = kept_val;
        end
    end

    // Sample register, written only when an item is accepted.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

@@ sv/swm_ring.sv @@
// Arrival-order ring of samples: one write port and one registered read
// port with write-first bypass. Depends on no package.
module swm_ring #(
    parameter int SAMPLE_BITS = 16,
    parameter int DEPTH       = 64,
    parameter int PTR_W       = 6
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [PTR_W-1:0]       wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_data,
    input  logic [PTR_W-1:0]       rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a write to the same slot is passed through.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/swm_tap.sv @@
// Median tap: picks the cell at the median index through a two-stage
// registered OR tree. Depends on swm_pkg.
module swm_tap #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int PTR_W       = 6
) (
    input  logic                   clk,
    input  logic [SAMPLE_BITS-1:0] vals [MAX_WINDOW],
    input  logic [PTR_W-1:0]       mid_idx,
    input  logic                   ld_group,
    input  logic                   ld_out,
    output logic [SAMPLE_BITS-1:0] median
);

    localparam int NGRP = (MAX_WINDOW + swm_pkg::GROUP - 1) / swm_pkg::GROUP;

    logic [SAMPLE_BITS-1:0] grp_next [NGRP];
    logic [SAMPLE_BITS-1:0] grp_reg  [NGRP];
    logic [SAMPLE_BITS-1:0] med_next;
    logic [SAMPLE_BITS-1:0] med_reg;

    // First level: within each group only the selected cell contributes.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < swm_pkg::GROUP; j++)
            begin
                if ((g * swm_pkg::GROUP + j) < MAX_WINDOW)
                begin
                    if (PTR_W'(g * swm_pkg::GROUP + j) == mid_idx)
                    begin
                        grp_next[g] = grp_next[g] | vals[g * swm_pkg::GROUP + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_group)
        begin
            grp_reg <= grp_next;
        end
    end

    // Second level: combine the group results.
    always_comb
    begin
        med_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            med_next = med_next | grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            med_reg <= med_next;
        end
    end

    assign median = med_reg;

endmodule

@@ sv/sliding_window_median_core.sv @@
// Sliding window lower median core: top level with the cell row, ring,
// median tap and handshake control. Depends on swm_pkg and assert_macros.svh.
//
// The core accepts one sample per clock unless a stalled output fills the
// pipe and, once the window holds window_size samples, returns the lower
// median (sorted index (window_size-1)/2) for every sample. The sorted copy
// lives in a row of MAX_WINDOW cells that remove the oldest sample and
// insert the new one in the same cycle; the oldest sample comes from a ring
// memory read one item ahead. Each median passes through three registered
// stages after its sample is accepted: the cell row, the first level of the
// median tap tree and the output register. The three stages hand off
// independently, so a stalled output holds up input only once all three are
// occupied. A window_size of zero acts as one, larger values saturate at
// MAX_WINDOW, and a write of the register empties the window. No clearing
// pass is needed after reset.
`include "assert_macros.svh"

module sliding_window_median_core #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: window_size.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]           cfg_data,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample
    input  logic                                s_axis_tuser,   // first_of_sequence
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata    // median
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int WIDE_W = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;

    logic [swm_pkg::CFG_W-1:0] window_size_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic [PTR_W-1:0]          rp_reg;
    logic [PTR_W-1:0]          rp_next;
    logic                      v1_reg;
    logic                      v1_next;
    logic                      v2_reg;
    logic                      v2_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic [WIDE_W-1:0]         w_wide;
    logic [CNT_W-1:0]          w_eff;
    logic [PTR_W-1:0]          mid_idx;
    logic [CNT_W-1:0]          n_cur;
    logic                      full;
    logic [CNT_W-1:0]          kept;
    logic [PTR_W-1:0]          rp_cur;
    logic [CNT_W-1:0]          rp_inc;
    logic [PTR_W-1:0]          rp_new;
    logic                      has_result;
    logic                      accept;
    logic                      cfg_write;
    logic                      ready1;
    logic                      ready2;
    logic                      adv1;
    logic                      adv2;
    logic [SAMPLE_BITS-1:0]    sample;
    logic [SAMPLE_BITS-1:0]    oldest;
    logic [SAMPLE_BITS-1:0]    median;
    swm_pkg::swm_ctrl_t        ctrl;

    logic [SAMPLE_BITS-1:0]    vals     [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]    kept_val [MAX_WINDOW];
    logic                      big      [MAX_WINDOW];

    assign sample    = s_axis_tdata[SAMPLE_BITS-1:0];
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Handshake: each stage moves when the one after it has room.
    assign ready2        = !out_valid_reg || m_axis_tready;
    assign ready1        = !v2_reg || ready2;
    assign s_axis_tready = !v1_reg || ready1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign adv1          = v1_reg && ready1;
    assign adv2          = v2_reg && ready2;

    // Effective window size and median index.
    always_comb
    begin
        w_wide = WIDE_W'(window_size_reg);
        if (w_wide == '0)
        begin
            w_wide = WIDE_W'(1);
        end
        else if (w_wide > WIDE_W'(MAX_WINDOW))
        begin
            w_wide = WIDE_W'(MAX_WINDOW);
        end
        w_eff   = CNT_W'(w_wide);
        mid_idx = PTR_W'((w_eff - CNT_W'(1)) >> 1);
    end

    // Fill count and ring pointer for the item on the input.
    always_comb
    begin
        n_cur  = s_axis_tuser ? '0 : fill_reg;
        rp_cur = s_axis_tuser ? '0 : rp_reg;
        if (CNT_W'(rp_cur) >= w_eff)
        begin
            rp_cur = '0;
        end
        full       = (n_cur >= w_eff);
        kept       = full ? (w_eff - CNT_W'(1)) : n_cur;
        fill_next  = full ? w_eff : (n_cur + CNT_W'(1));
        has_result = (fill_next >= w_eff);
        rp_inc     = CNT_W'(rp_cur) + CNT_W'(1);
        rp_new     = (rp_inc >= w_eff) ? '0 : PTR_W'(rp_inc);
        if (cfg_write)
        begin
            rp_next = '0;
        end
        else if (accept)
        begin
            rp_next = rp_new;
        end
        else
        begin
            rp_next = rp_reg;
        end
    end

    // Pipeline valid flags.
    always_comb
    begin
        v1_next = v1_reg;
        if (accept)
        begin
            v1_next = has_result;
        end
        else if (adv1)
        begin
            v1_next = 1'b0;
        end

        v2_next = v2_reg;
        if (adv1)
        begin
            v2_next = 1'b1;
        end
        else if (adv2)
        begin
            v2_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv2)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WINDOW_RESET;
            fill_reg        <= '0;
            rp_reg          <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rp_reg        <= rp_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                window_size_reg <= cfg_data;
                fill_reg        <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Arrival ring; the read port always holds the sample in the next slot.
    swm_ring #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (MAX_WINDOW),
        .PTR_W       (PTR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (rp_cur),
        .wr_data (sample),
        .rd_addr (rp_next),
        .rd_data (oldest)
    );

    // Sorted cell row.
    assign ctrl.load = accept;
    assign ctrl.full = full;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] right_val;
        logic [SAMPLE_BITS-1:0] left_kept_val;
        logic                   left_big;

        if (i < MAX_WINDOW - 1)
        begin : g_right
            assign right_val = vals[i+1];
        end
        else
        begin : g_last
            assign right_val = '0;
        end

        if (i > 0)
        begin : g_left
            assign left_kept_val = kept_val[i-1];
            assign left_big      = big[i-1];
        end
        else
        begin : g_first
            assign left_kept_val = '0;
            assign left_big      = 1'b0;
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_W       (CNT_W),
            .INDEX       (i)
        ) u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .sample        (sample),
            .oldest        (oldest),
            .kept          (kept),
            .right_val     (right_val),
            .left_kept_val (left_kept_val),
            .left_big      (left_big),
            .val           (vals[i]),
            .kept_val      (kept_val[i]),
            .big           (big[i])
        );
    end

    // Median tap and output register.
    swm_tap #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW),
        .PTR_W       (PTR_W)
    ) u_tap (
        .clk      (clk),
        .vals     (vals),
        .mid_idx  (mid_idx),
        .ld_group (adv1),
        .ld_out   (adv2),
        .median   (median)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(median);

    // The window never holds more samples than its size.
    `SWM_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= w_eff)
    // The ring pointer stays inside the window.
    `SWM_ASSERT_ALWAYS(a_ptr_bound, clk, rst_n, CNT_W'(rp_reg) < w_eff)
    // An accepted item that completes a window leaves a result in the cell row.
    `SWM_ASSERT_NEXT(a_result_pending, clk, rst_n, accept && has_result, v1_reg)

endmodule

@@ tb/swm_median_checker.sv @@
// Checker for the sliding window median core: tracks the window size register,
// keeps its own window of samples and compares every median that leaves the core.
// Depends on swm_pkg for the register width, its reset value and the default window.
`timescale 1ns / 100ps

module swm_median_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0] cfg_data,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [15:0]              s_axis_tdata,   // sample
    input  logic                     s_axis_tuser,   // first_of_sequence
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [15:0]              m_axis_tdata,   // median
    output int                       errors,
    output int                       pending,
    output int                       medians_seen
);

    localparam int MAX_WIN = swm_pkg::MAX_WINDOW_DEF;

    // Mirror of the core's window: arrival order and ascending order.
    logic [15:0]              arrival [MAX_WIN];
    logic [15:0]              ascending [MAX_WIN];
    int                       oldest_slot;
    int                       held;
    logic [swm_pkg::CFG_W-1:0] window_reg;

    // Medians predicted but not yet seen on the output.
    logic [15:0]              median_q [$];

    initial
    begin
        errors       = 0;
        pending      = 0;
        medians_seen = 0;
        oldest_slot  = 0;
        held         = 0;
        window_reg   = swm_pkg::WINDOW_RESET;
    end

    // A size of zero acts as one; anything past the row length saturates.
    function automatic int active_window();
        int w;
        w = int'(window_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WIN)
            w = MAX_WIN;
        return w;
    endfunction

    // Insert a value into the first n ascending entries.
    task automatic sorted_insert(input int n, input logic [15:0] v);
        int i;
        i = n;
        while (i > 0 && ascending[i - 1] > v)
        begin
            ascending[i] = ascending[i - 1];
            i--;
        end
        ascending[i] = v;
    endtask

    // Take one entry equal to v out of the first n ascending entries.
    task automatic sorted_drop(input int n, input logic [15:0] v);
        int j;
        j = 0;
        while (j < n && ascending[j] != v)
            j++;
        if (j >= n)
            j = n - 1;
        while (j + 1 < n)
        begin
            ascending[j] = ascending[j + 1];
            j++;
        end
    endtask

    // Advance the window by one sample and queue a median once it is full.
    task automatic predict_median(input logic [15:0] v, input logic restart);
        int w;
        int slot;
        w = active_window();
        if (restart)
        begin
            oldest_slot = 0;
            held        = 0;
        end
        slot = oldest_slot;
        if (slot >= w)
            slot = 0;
        if (held < w)
        begin
            sorted_insert(held, v);
            held++;
        end
        else
        begin
            sorted_drop(w, arrival[slot]);
            sorted_insert(w - 1, v);
        end
        arrival[slot] = v;
        slot++;
        if (slot >= w)
            slot = 0;
        oldest_slot = slot;
        if (held >= w)
            median_q.push_back(ascending[(w - 1) / 2]);
    endtask

    // Outputs are compared before the sample of the same edge is predicted;
    // the core cannot answer a sample in the cycle it takes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                medians_seen++;
                if (median_q.size() == 0)
                begin
                    $error("median: no result expected, got %0d", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    logic [15:0] want;
                    want = median_q.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $error("median: expected %0d, got %0d", want, m_axis_tdata);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                window_reg  = cfg_data;
                oldest_slot = 0;
                held        = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_median(s_axis_tdata, s_axis_tuser);
            pending = median_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the sliding window median testbench: clock, reset, stimulus and verdict.
// Depends on sliding_window_median_core, swm_pkg and swm_median_checker.
`timescale 1ns / 100ps

module tb;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [swm_pkg::CFG_W-1:0] cfg_data      = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [15:0]               s_axis_tdata  = '0;   // sample
    logic                      s_axis_tuser  = 1'b0; // first_of_sequence
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [15:0]               m_axis_tdata;         // median

    int errors;
    int pending;
    int medians_seen;

    // Stimulus bookkeeping.
    int          samples_sent = 0;
    int          writes_done  = 0;
    int          burst_left   = 0;
    logic [15:0] drift_level  = 16'd1000;

    // Receiver stall pattern.
    logic [7:0]  stall_pat  = 8'hFF;
    int          stall_left = 0;

    sliding_window_median_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    swm_median_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending),
        .medians_seen  (medians_seen)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver follows a rotating pattern that is redrawn whenever its hold count runs out;
    // about a quarter of the patterns never stall.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                stall_pat = 8'hFF;
            else
                stall_pat = 8'($urandom_range(0, 255)) | 8'h01;
            stall_left = $urandom_range(20, 80);
        end
        else
            stall_left--;
        stall_pat = {stall_pat[0], stall_pat[7:1]};
        m_axis_tready <= stall_pat[0];
    end

    // Offer one item and hold it until the core takes it. Bursts of random
    // length are separated by random gaps, some of them empty.
    task automatic send_sample(input logic [15:0] v, input logic restart);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_axis_tready);
        samples_sent++;
    endtask

    // Write the window size once the core has drained; the extra cycles cover
    // samples that are still in the pipe without a median behind them.
    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] size);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        writes_done++;
    endtask

    // Mix of full range values, heavy duplicates, extremes and a slow drift.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, 65535));
            4, 5, 6:    return 16'($urandom_range(0, 7));
            7:          return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:
            begin
                drift_level = drift_level + 16'($urandom_range(0, 64)) - 16'd32;
                return drift_level;
            end
        endcase
    endfunction

    // Stimulus: directed samples at the reset size, then random phases.
    initial
    begin
        logic [15:0]               dir_s [22] = '{16'd0, 16'd65535, 16'd65535, 16'd0,
                                                  16'd0, 16'd65535, 16'd1, 16'd1,
                                                  16'd1, 16'd32768, 16'd32767, 16'd0,
                                                  16'd65535, 16'h5555, 16'hAAAA, 16'h00FF,
                                                  16'hFF00, 16'd7, 16'd7, 16'd3,
                                                  16'd100, 16'd65535};
        logic                      dir_f [22] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                                  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                                  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                                  1'b0, 1'b0, 1'b0, 1'b0};
        logic [swm_pkg::CFG_W-1:0] sizes [14] = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd5, 7'd127,
                                                  7'd4, 7'd65, 7'd7, 7'd63, 7'd3, 7'd9,
                                                  7'd16, 7'd6};
        logic [swm_pkg::CFG_W-1:0] size;
        int                        phase;
        int                        count;
        int                        random_sent;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, bit patterns, duplicates and restarts,
        // including restarts on back to back samples.
        for (int i = 0; i < 22; i++)
            send_sample(dir_s[i], dir_f[i]);

        // Random part: listed sizes first, then mostly small random sizes.
        random_sent = 0;
        phase       = 0;
        while (random_sent < 1100)
        begin
            if (phase < 14)
                size = sizes[phase];
            else if ($urandom_range(0, 4) == 0)
                size = 7'($urandom_range(0, 127));
            else
                size = 7'($urandom_range(1, 12));
            write_window(size);
            count = (size > 16) ? 150 : 60;
            for (int i = 0; i < count; i++)
            begin
                send_sample(pick_sample(),
                            (i == 0) ? 1'($urandom_range(0, 1))
                                     : ($urandom_range(0, 49) == 0));
                random_sent++;
            end
            phase++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain and let the pipe settle; the first wait lets the checker
        // record the last accepted item.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d samples under %0d window size writes.",
                 samples_sent, writes_done);
        $display("%0d medians were compared against the prediction.", medians_seen);
        if (pending != 0)
            $error("%0d predicted medians never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/swm_pkg.sv
sv/swm_cell.sv
sv/swm_ring.sv
sv/swm_tap.sv
sv/sliding_window_median_core.sv
tb/swm_median_checker.sv
tb/tb.sv
